FILE: hdl/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and constants of the touch contact tracker: beat codes, the
// contact entry held by each chain cell and the control word sent to the row.
// ----------------------------------------------------------------------------
`default_nettype none

package tct_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned LIVE_W   = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PHASE_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_DOWN   = 2'd0,
    MODE_MOTION = 2'd1,
    MODE_UP     = 2'd2,
    MODE_TICK   = 2'd3
  } tct_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_UPDATED   = 3'd0,
    STAT_INSERTED  = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_TICK      = 3'd4
  } tct_status_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_NONE = 2'd0,
    PH_DOWN = 2'd1,
    PH_HELD = 2'd2,
    PH_UP   = 2'd3
  } tct_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT,
    ST_REPORT,
    ST_EMPTY
  } tct_state_e;

  // One contact as held in a chain cell
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             now_pressed;
    logic             was_pressed;
    logic             latch;
    tct_phase_e       phase;
  } tct_entry_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic              shift;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_ptr;
  } tct_cell_ctl_t;

endpackage : tct_pkg

`default_nettype wire

FILE: hdl/tct_cell.sv
// ----------------------------------------------------------------------------
// tct_cell
// One cell of the contact chain. Holds one entry; on a shift it takes the
// entry of its upper neighbor, and a broadcast write at its index overrides.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_cell #(
  parameter logic [tct_pkg::SLOT_W-1:0] INDEX = '0
) (
  input  wire                    clk_i,
  input  tct_pkg::tct_cell_ctl_t ctl_i,
  input  tct_pkg::tct_entry_t    nbr_i,
  input  tct_pkg::tct_entry_t    wr_data_i,
  output tct_pkg::tct_entry_t    ent_o
);

  import tct_pkg::*;

  tct_entry_t ent_q;
  tct_entry_t ent_d;

  // Select write, neighbor or hold
  always_comb begin
    ent_d = ent_q;
    if (ctl_i.wr_en && (ctl_i.wr_ptr == INDEX)) begin
      ent_d = wr_data_i;
    end else if (ctl_i.shift) begin
      ent_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule : tct_cell

`default_nettype wire

FILE: hdl/tct_ctrl.sv
// ----------------------------------------------------------------------------
// tct_ctrl
// Sequencer of the contact tracker. Rotates the chain through its head cell
// to look up, compact and report entries, and owns the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_ctrl #(
  parameter int unsigned MAX_CONTACTS = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // input beats
  input  wire                    s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire  [63:0]            s_axis_tdata_i,  // touch_id, pos_x, pos_y
  input  wire  [1:0]             s_axis_tuser_i,  // mode
  // result beats
  output logic                   m_axis_tvalid_o,
  input  wire                    m_axis_tready_i,
  output logic [79:0]            m_axis_tdata_o,  // slot, contact_id, report_x,
                                                  // report_y, phase, live_count
  output logic [3:0]             m_axis_tuser_o,  // status, entry_valid
  output logic                   m_axis_tlast_o,
  // chain
  input  tct_pkg::tct_entry_t    head_i,
  output tct_pkg::tct_cell_ctl_t ctl_o,
  output tct_pkg::tct_entry_t    wr_data_o
);

  import tct_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CONTACTS + 1);

  tct_state_e state_q, state_d;

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [CW-1:0]    kept_q, kept_d;
  logic             found_q, found_d;
  logic [CW-1:0]    fidx_q, fidx_d;
  tct_entry_t       hit_q, hit_d;
  tct_mode_e        mode_q, mode_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [POS_W-1:0] x_q, x_d;
  logic [POS_W-1:0] y_q, y_d;

  // result register
  logic              ovalid_q, ovalid_d;
  tct_status_e       ostat_q, ostat_d;
  logic              oev_q, oev_d;
  logic [SLOT_W-1:0] oslot_q, oslot_d;
  logic [ID_W-1:0]   oid_q, oid_d;
  logic [POS_W-1:0]  ox_q, ox_d;
  logic [POS_W-1:0]  oy_q, oy_d;
  tct_phase_e        oph_q, oph_d;
  logic [LIVE_W-1:0] olive_q, olive_d;
  logic              olast_q, olast_d;

  logic          accept;
  logic          out_free;
  logic          rem_zero;
  logic          head_hit;
  logic          head_cur;
  tct_phase_e    head_ph;
  tct_entry_t    head_mod;
  logic [CW-1:0] step_idx;
  logic [CW-1:0] tail_ptr;
  logic [CW-1:0] keep_ptr;
  logic          has_room;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ovalid_q || m_axis_tready_i;
  assign rem_zero = (rem_q == '0);
  assign step_idx = cnt_q - rem_q;
  assign tail_ptr = cnt_q - 1'b1;
  assign keep_ptr = rem_q - 1'b1 + kept_q;
  assign has_room = (cnt_q < CW'(MAX_CONTACTS));

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Match and update of the head entry
  always_comb begin
    head_hit = !found_q && (head_i.id == id_q);
    head_mod = head_i;
    unique case (mode_q)
      MODE_DOWN: begin
        head_mod.now_pressed = 1'b1;
        head_mod.latch       = 1'b1;
        head_mod.x           = x_q;
        head_mod.y           = y_q;
      end
      MODE_MOTION: begin
        head_mod.x = x_q;
        head_mod.y = y_q;
      end
      MODE_UP: begin
        head_mod.now_pressed = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Classify the head entry for a tick
  always_comb begin
    head_cur = head_i.now_pressed | head_i.latch;
    case ({head_i.was_pressed, head_cur})
      2'b01:   head_ph = PH_DOWN;
      2'b11:   head_ph = PH_HELD;
      2'b10:   head_ph = PH_UP;
      default: head_ph = PH_NONE;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (tct_mode_e'(s_axis_tuser_i) == MODE_TICK) ? ST_COMPACT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rem_zero && out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_COMPACT: begin
        if (rem_zero) begin
          state_d = (kept_q == '0) ? ST_EMPTY : ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free && (rem_q == CW'(1))) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, chain control and result register
  always_comb begin
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    kept_d  = kept_q;
    found_d = found_q;
    fidx_d  = fidx_q;
    hit_d   = hit_q;
    mode_d  = mode_q;
    id_d    = id_q;
    x_d     = x_q;
    y_d     = y_q;

    ovalid_d = ovalid_q && !m_axis_tready_i;
    ostat_d  = ostat_q;
    oev_d    = oev_q;
    oslot_d  = oslot_q;
    oid_d    = oid_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    oph_d    = oph_q;
    olive_d  = olive_q;
    olast_d  = olast_q;

    ctl_o     = '0;
    wr_data_o = head_i;

    unique case (state_q)
      ST_IDLE: begin
        // latch the beat and start a pass over the chain
        if (accept) begin
          mode_d  = tct_mode_e'(s_axis_tuser_i);
          id_d    = s_axis_tdata_i[31:0];
          x_d     = s_axis_tdata_i[47:32];
          y_d     = s_axis_tdata_i[63:48];
          rem_d   = cnt_q;
          kept_d  = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (!rem_zero) begin
          // rotate the head to the tail, updating the first match
          ctl_o.shift  = 1'b1;
          ctl_o.wr_en  = 1'b1;
          ctl_o.wr_ptr = SLOT_W'(tail_ptr);
          if (head_hit) begin
            wr_data_o = head_mod;
            found_d   = 1'b1;
            fidx_d    = step_idx;
            hit_d     = head_mod;
          end
          rem_d = rem_q - 1'b1;
        end else if (out_free) begin
          ovalid_d = 1'b1;
          oev_d    = 1'b0;
          oph_d    = PH_NONE;
          olast_d  = 1'b1;
          olive_d  = LIVE_W'(cnt_q);
          if (found_q) begin
            ostat_d = STAT_UPDATED;
            oslot_d = SLOT_W'(fidx_q);
            oid_d   = hit_q.id;
            ox_d    = hit_q.x;
            oy_d    = hit_q.y;
          end else if ((mode_q == MODE_DOWN) && has_room) begin
            // append a new contact after the last entry
            ctl_o.wr_en           = 1'b1;
            ctl_o.wr_ptr          = SLOT_W'(cnt_q);
            wr_data_o.id          = id_q;
            wr_data_o.x           = x_q;
            wr_data_o.y           = y_q;
            wr_data_o.now_pressed = 1'b1;
            wr_data_o.was_pressed = 1'b0;
            wr_data_o.latch       = 1'b1;
            wr_data_o.phase       = PH_NONE;
            cnt_d   = cnt_q + 1'b1;
            ostat_d = STAT_INSERTED;
            oslot_d = SLOT_W'(cnt_q);
            oid_d   = id_q;
            ox_d    = x_q;
            oy_d    = y_q;
            olive_d = LIVE_W'(cnt_q + 1'b1);
          end else begin
            ostat_d = (mode_q == MODE_DOWN) ? STAT_FULL : STAT_NOT_FOUND;
            oslot_d = '0;
            oid_d   = '0;
            ox_d    = '0;
            oy_d    = '0;
          end
        end
      end
      ST_COMPACT: begin
        if (!rem_zero) begin
          // pop the head; push it behind the kept entries unless finished
          ctl_o.shift = 1'b1;
          if (head_ph != PH_NONE) begin
            ctl_o.wr_en           = 1'b1;
            ctl_o.wr_ptr          = SLOT_W'(keep_ptr);
            wr_data_o.was_pressed = head_cur;
            wr_data_o.latch       = 1'b0;
            wr_data_o.phase       = head_ph;
            kept_d = kept_q + 1'b1;
          end
          rem_d = rem_q - 1'b1;
        end else begin
          cnt_d = kept_q;
          rem_d = kept_q;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          // report the head and rotate it to the tail
          ctl_o.shift  = 1'b1;
          ctl_o.wr_en  = 1'b1;
          ctl_o.wr_ptr = SLOT_W'(tail_ptr);
          ovalid_d = 1'b1;
          ostat_d  = STAT_TICK;
          oev_d    = 1'b1;
          oslot_d  = SLOT_W'(step_idx);
          oid_d    = head_i.id;
          ox_d     = head_i.x;
          oy_d     = head_i.y;
          oph_d    = head_i.phase;
          olive_d  = LIVE_W'(cnt_q);
          olast_d  = (rem_q == CW'(1));
          rem_d    = rem_q - 1'b1;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ostat_d  = STAT_TICK;
          oev_d    = 1'b0;
          oslot_d  = '0;
          oid_d    = '0;
          ox_d     = '0;
          oy_d     = '0;
          oph_d    = PH_NONE;
          olive_d  = '0;
          olast_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      kept_q   <= '0;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      kept_q   <= kept_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fidx_q  <= fidx_d;
    hit_q   <= hit_d;
    mode_q  <= mode_d;
    id_q    <= id_d;
    x_q     <= x_d;
    y_q     <= y_d;
    ostat_q <= ostat_d;
    oev_q   <= oev_d;
    oslot_q <= oslot_d;
    oid_q   <= oid_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    oph_q   <= oph_d;
    olive_q <= olive_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {1'b0, olive_q, oph_q, oy_q, ox_q, oid_q, oslot_q};
  assign m_axis_tuser_o  = {oev_q, ostat_q};
  assign m_axis_tlast_o  = olast_q;

endmodule : tct_ctrl

`default_nettype wire

FILE: hdl/touch_contact_tracker.sv
// Event beat (down, motion, up): one pass over the chain, then the result beat.
// Tick beat: a compaction pass, then one report beat per kept entry (one beat
// when none is kept). The chain rotates one cell a cycle, but not while a report
// is stalled. One beat is worked at a time; a new beat is taken while a result
// waits. Reset clears the entry count and control; cell contents stay undefined.
// ----------------------------------------------------------------------------
// touch_contact_tracker
// Table of active touch contacts kept in a shifting row of cells, matched by
// id, with per-tick classification, compaction and reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_contact_tracker #(
  parameter int unsigned MAX_CONTACTS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [63:0] s_axis_tdata_i,   // touch_id[31:0], pos_x[47:32], pos_y[63:48]
  input  wire  [1:0]  s_axis_tuser_i,   // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // slot[5:0], contact_id[37:6], report_x[53:38],
                                        // report_y[69:54], phase[71:70],
                                        // live_count[78:72], zero[79]
  output logic [3:0]  m_axis_tuser_o,   // status[2:0], entry_valid[3]
  output logic        m_axis_tlast_o
);

  import tct_pkg::*;

  tct_cell_ctl_t ctl;
  tct_entry_t    wr_data;
  tct_entry_t    ent [MAX_CONTACTS+1];

  // Nothing enters above the top cell
  assign ent[MAX_CONTACTS] = '0;

  // Row of contact cells, cell 0 is the head
  for (genvar g = 0; g < MAX_CONTACTS; g++) begin : g_cell
    tct_cell #(
      .INDEX (SLOT_W'(g))
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .nbr_i     (ent[g+1]),
      .wr_data_i (wr_data),
      .ent_o     (ent[g])
    );
  end

  tct_ctrl #(
    .MAX_CONTACTS (MAX_CONTACTS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .head_i          (ent[0]),
    .ctl_o           (ctl),
    .wr_data_o       (wr_data)
  );

endmodule : touch_contact_tracker

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the touch contact tracker. Event and tick beats go
// in through the slave stream. A local copy of the contact table predicts
// every result beat, and each beat from the master stream is checked against
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tct_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned GAP_PCT = 32;

  // One input beat as queued for the driver
  typedef struct {
    tct_mode_e   mode;
    logic [31:0] id;
    logic [15:0] x;
    logic [15:0] y;
    bit          drain;
  } touch_event_t;

  // One contact of the local table
  typedef struct {
    logic [31:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic        now_pressed;
    logic        was_pressed;
    logic        latch;
  } contact_t;

  // One predicted result beat
  typedef struct {
    tct_status_e status;
    logic        valid;
    logic [5:0]  slot;
    logic [31:0] id;
    logic [15:0] x;
    logic [15:0] y;
    tct_phase_e  phase;
    logic [6:0]  live;
    logic        last;
  } contact_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;    // touch_id[31:0], pos_x[47:32], pos_y[63:48]
  logic [1:0]  s_tuser = '0;    // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;         // slot, contact_id, report_x, report_y, phase, live_count
  logic [3:0]  m_tuser;         // status[2:0], entry_valid[3]
  logic        m_tlast;

  touch_contact_tracker #(
    .MAX_CONTACTS(TABLE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  touch_event_t    pending_events[$];
  contact_report_t expected_reports[$];
  contact_t        contacts[TABLE_DEPTH];
  int unsigned     live_contacts = 0;

  int unsigned total_events = 0;
  int unsigned accepted_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned tick_cnt = 0;
  int unsigned full_drops = 0;
  int unsigned unknown_ids = 0;
  int unsigned peak_live = 0;
  int unsigned report_beats = 0;
  logic        in_taken = 1'b0;
  logic        steady;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Keep both sides busy without gaps over one stretch of the run
  assign steady = (accepted_cnt >= 120) && (accepted_cnt < 200);

  // Report one mismatch; keep the log short on a badly broken block
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_cnt < 40) begin
      $display("MISMATCH at cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, what, got, want);
    end
    error_cnt++;
  endtask

  task automatic expect_report(tct_status_e status, logic valid, int unsigned slot,
                               logic [31:0] id, logic [15:0] x, logic [15:0] y,
                               tct_phase_e phase, int unsigned live, logic last);
    contact_report_t r;
    r.status = status;
    r.valid  = valid;
    r.slot   = slot[5:0];
    r.id     = id;
    r.x      = x;
    r.y      = y;
    r.phase  = phase;
    r.live   = live[6:0];
    r.last   = last;
    expected_reports.push_back(r);
  endtask

  // Advance the local contact table by one beat and queue its results
  task automatic track_contacts(tct_mode_e mode, logic [31:0] id, logic [15:0] x,
                                logic [15:0] y);
    int         hit;
    int unsigned kept;
    logic       cur;
    tct_phase_e ph;
    tct_phase_e phases[TABLE_DEPTH];
    hit  = -1;
    kept = 0;
    if (mode == MODE_TICK) begin
      tick_cnt++;
      // Classify, then compact in order
      for (int unsigned i = 0; i < live_contacts; i++) begin
        cur = contacts[i].now_pressed | contacts[i].latch;
        if (!contacts[i].was_pressed && cur) ph = PH_DOWN;
        else if (contacts[i].was_pressed && cur) ph = PH_HELD;
        else if (contacts[i].was_pressed && !cur) ph = PH_UP;
        else ph = PH_NONE;
        if (ph != PH_NONE) begin
          contacts[kept] = contacts[i];
          contacts[kept].was_pressed = cur;
          contacts[kept].latch = 1'b0;
          phases[kept] = ph;
          kept++;
        end
      end
      live_contacts = kept;
      if (kept == 0) begin
        expect_report(STAT_TICK, 1'b0, 0, '0, '0, '0, PH_NONE, 0, 1'b1);
      end else begin
        for (int unsigned i = 0; i < kept; i++) begin
          expect_report(STAT_TICK, 1'b1, i, contacts[i].id, contacts[i].x, contacts[i].y,
                        phases[i], kept, i + 1 == kept);
        end
      end
      return;
    end
    for (int unsigned i = 0; i < live_contacts; i++) begin
      if (hit < 0 && contacts[i].id == id) hit = i;
    end
    if (hit >= 0) begin
      case (mode)
        MODE_DOWN: begin
          contacts[hit].now_pressed = 1'b1;
          contacts[hit].latch = 1'b1;
          contacts[hit].x = x;
          contacts[hit].y = y;
        end
        MODE_MOTION: begin
          contacts[hit].x = x;
          contacts[hit].y = y;
        end
        default: begin
          contacts[hit].now_pressed = 1'b0;
        end
      endcase
      expect_report(STAT_UPDATED, 1'b0, hit, contacts[hit].id, contacts[hit].x,
                    contacts[hit].y, PH_NONE, live_contacts, 1'b1);
    end else if (mode == MODE_DOWN && live_contacts < TABLE_DEPTH) begin
      contacts[live_contacts] = '{id, x, y, 1'b1, 1'b0, 1'b1};
      live_contacts++;
      if (live_contacts > peak_live) peak_live = live_contacts;
      expect_report(STAT_INSERTED, 1'b0, live_contacts - 1, id, x, y, PH_NONE,
                    live_contacts, 1'b1);
    end else if (mode == MODE_DOWN) begin
      full_drops++;
      expect_report(STAT_FULL, 1'b0, 0, '0, '0, '0, PH_NONE, live_contacts, 1'b1);
    end else begin
      unknown_ids++;
      expect_report(STAT_NOT_FOUND, 1'b0, 0, '0, '0, '0, PH_NONE, live_contacts, 1'b1);
    end
  endtask

  task automatic push_event(tct_mode_e mode, logic [31:0] id, logic [15:0] x,
                            logic [15:0] y, bit drain = 1'b0);
    touch_event_t ev;
    ev.mode  = mode;
    ev.id    = id;
    ev.x     = x;
    ev.y     = y;
    ev.drain = drain;
    pending_events.push_back(ev);
  endtask

  // Driver: take the beat at the rising edge, offer the next at the falling edge
  always @(posedge clk_i) begin
    in_taken <= s_tvalid && s_tready;
    if (rst_ni && s_tvalid && s_tready) begin
      track_contacts(tct_mode_e'(s_tuser), s_tdata[31:0], s_tdata[47:32], s_tdata[63:48]);
      accepted_cnt++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || in_taken)) begin
      if (pending_events.size() > 0 &&
          !(pending_events[0].drain && expected_reports.size() != 0) &&
          (steady || $urandom_range(99) >= GAP_PCT)) begin
        s_tdata  <= {pending_events[0].y, pending_events[0].x, pending_events[0].id};
        s_tuser  <= pending_events[0].mode;
        s_tvalid <= 1'b1;
        void'(pending_events.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_tready <= steady || ($urandom_range(99) >= GAP_PCT);
    end
  end

  // Monitor: check each result beat against the oldest prediction
  always @(posedge clk_i) begin
    contact_report_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      report_beats++;
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result beat, contact_id", m_tdata[37:6], '0);
      end else begin
        want = expected_reports.pop_front();
        if (m_tuser[2:0] !== want.status)
          report_mismatch("status", 32'(m_tuser[2:0]), 32'(want.status));
        if (m_tuser[3] !== want.valid)
          report_mismatch("entry_valid", 32'(m_tuser[3]), 32'(want.valid));
        if (m_tdata[5:0] !== want.slot)
          report_mismatch("slot", 32'(m_tdata[5:0]), 32'(want.slot));
        if (m_tdata[37:6] !== want.id) report_mismatch("contact_id", m_tdata[37:6], want.id);
        if (m_tdata[53:38] !== want.x)
          report_mismatch("report_x", 32'(m_tdata[53:38]), 32'(want.x));
        if (m_tdata[69:54] !== want.y)
          report_mismatch("report_y", 32'(m_tdata[69:54]), 32'(want.y));
        if (m_tdata[71:70] !== want.phase)
          report_mismatch("phase", 32'(m_tdata[71:70]), 32'(want.phase));
        if (m_tdata[78:72] !== want.live)
          report_mismatch("live_count", 32'(m_tdata[78:72]), 32'(want.live));
        if (m_tlast !== want.last) report_mismatch("last", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_reports.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [31:0] ids[$];
    int unsigned random_cnt;
    int unsigned episode;
    int unsigned fresh;
    int unsigned steps;
    int unsigned pick;
    logic [31:0] new_id;
    tct_mode_e   m;

    // Directed: empty tick, extremes, update, unknown ids, mid-table removal
    push_event(MODE_TICK, 32'h0, 16'h0, 16'h0);
    push_event(MODE_DOWN, 32'h0000_0000, 16'h0000, 16'h0000);
    push_event(MODE_DOWN, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    push_event(MODE_DOWN, 32'h8000_0001, 16'h8000, 16'h0001);
    push_event(MODE_DOWN, 32'h0000_0000, 16'h1234, 16'h8001);
    push_event(MODE_MOTION, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
    push_event(MODE_MOTION, 32'h1234_5678, 16'hAAAA, 16'h5555);
    push_event(MODE_UP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    push_event(MODE_UP, 32'h5A5A_5A5A, 16'h0, 16'h0);
    // Released before the tick: the latch still reports it as just down
    push_event(MODE_TICK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    push_event(MODE_TICK, 32'h0, 16'h0, 16'h0);
    push_event(MODE_MOTION, 32'hFFFF_FFFF, 16'h7FFF, 16'hFFFE);
    // Middle entry drops out, the last one moves down a slot
    push_event(MODE_TICK, 32'h0, 16'h0, 16'h0);
    push_event(MODE_MOTION, 32'hFFFF_FFFF, 16'h0001, 16'h0001);
    push_event(MODE_UP, 32'h0000_0000, 16'h0, 16'h0);
    push_event(MODE_DOWN, 32'h0000_0000, 16'h4321, 16'h1111);
    push_event(MODE_UP, 32'h8000_0001, 16'h0, 16'h0);
    push_event(MODE_TICK, 32'h0, 16'h0, 16'h0);
    push_event(MODE_UP, 32'h0000_0000, 16'h0, 16'h0);
    push_event(MODE_TICK, 32'h0, 16'h0, 16'h0);
    push_event(MODE_TICK, 32'h0, 16'h0, 16'h0);
    push_event(MODE_TICK, 32'h0, 16'h0, 16'h0);

    // Random gestures: presses, moves, releases and ticks, with some noise
    random_cnt = 0;
    episode = 0;
    while (random_cnt < RANDOM_ITEMS) begin
      ids.delete();
      fresh = ($urandom_range(4) == 0) ? $urandom_range(TABLE_DEPTH - 1, TABLE_DEPTH + 2)
                                       : $urandom_range(1, 6);
      for (int unsigned i = 0; i < fresh; i++) begin
        new_id = $urandom();
        ids.push_back(new_id);
        push_event(MODE_DOWN, new_id, 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), i == 0 && episode % 3 == 2);
      end
      steps = $urandom_range(fresh, 3 * fresh + 4);
      for (int unsigned i = 0; i < steps; i++) begin
        pick = $urandom_range(99);
        new_id = ids[$urandom_range(ids.size() - 1)];
        if (pick < 12) begin
          m = MODE_TICK;
        end else if (pick < 45) begin
          m = MODE_MOTION;
        end else if (pick < 60) begin
          m = MODE_DOWN;
        end else if (pick < 75) begin
          m = MODE_UP;
        end else if (pick < 83) begin
          m = MODE_DOWN;
          new_id = $urandom();
          ids.push_back(new_id);
        end else begin
          m = (pick < 92) ? MODE_MOTION : MODE_UP;
          new_id = $urandom();
        end
        push_event(m, new_id, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
      end
      // Release everything and let the table drain
      foreach (ids[i]) push_event(MODE_UP, ids[i], 16'($urandom_range(65535)),
                                  16'($urandom_range(65535)));
      for (int unsigned i = 0; i < 3; i++) begin
        push_event(MODE_TICK, $urandom(), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
      end
      random_cnt += 2 * fresh + steps + ids.size() + 3 - fresh;
      episode++;
    end
    total_events = pending_events.size();

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_cnt == total_events && expected_reports.size() == 0);
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d input beats (%0d ticks) and %0d result beats.",
             accepted_cnt, tick_cnt, report_beats);
    $display("Full-table drops %0d, unknown ids %0d, largest table %0d contacts.",
             full_drops, unknown_ids, peak_live);
    if (error_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : tb
